FILE: hdl/mdsha_pkg.sv
// Package for the midstate double SHA-256 target check unit.
// Holds round constants, IV, stage types and SHA-256 helper functions; no dependencies.
package mdsha_pkg;

    localparam int unsigned NumRounds = 64;

    typedef logic [31:0] word_t;
    typedef word_t [7:0]  state_t;
    typedef word_t [15:0] sched_t;

    localparam word_t RoundK [NumRounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam state_t StdIv = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Block padding words
    localparam word_t PadFirst   = 32'h8000_0000;
    localparam word_t LenFirst   = 32'h0000_0400;
    localparam word_t LenSecond  = 32'h0000_0100;

    // Config register indexes
    localparam logic [2:0] RegMid0   = 3'd0;
    localparam logic [2:0] RegMid1   = 3'd1;
    localparam logic [2:0] RegMid2   = 3'd2;
    localparam logic [2:0] RegMid3   = 3'd3;
    localparam logic [2:0] RegTarget = 3'd4;
    localparam logic [31:0] TargetReset = 32'h1d00ffff;

    // One pipeline slot: working vars, message window, chaining value
    typedef struct packed {
        state_t wv;
        sched_t w;
        state_t base;
    } slot_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    // One round plus one schedule step; window slides down by one word
    function automatic slot_t sha_round(input slot_t s, input word_t k);
        word_t t1;
        word_t t2;
        word_t s0;
        word_t s1;
        word_t wn;
        slot_t r;
        t1 = s.wv[7] + (rotr(s.wv[4], 6) ^ rotr(s.wv[4], 11) ^ rotr(s.wv[4], 25))
             + ((s.wv[4] & s.wv[5]) ^ (~s.wv[4] & s.wv[6])) + k + s.w[0];
        t2 = (rotr(s.wv[0], 2) ^ rotr(s.wv[0], 13) ^ rotr(s.wv[0], 22))
             + ((s.wv[0] & s.wv[1]) ^ (s.wv[0] & s.wv[2]) ^ (s.wv[1] & s.wv[2]));
        s0 = rotr(s.w[1], 7) ^ rotr(s.w[1], 18) ^ (s.w[1] >> 3);
        s1 = rotr(s.w[14], 17) ^ rotr(s.w[14], 19) ^ (s.w[14] >> 10);
        wn = s.w[0] + s0 + s.w[9] + s1;
        r = s;
        r.wv[7] = s.wv[6];
        r.wv[6] = s.wv[5];
        r.wv[5] = s.wv[4];
        r.wv[4] = s.wv[3] + t1;
        r.wv[3] = s.wv[2];
        r.wv[2] = s.wv[1];
        r.wv[1] = s.wv[0];
        r.wv[0] = t1 + t2;
        for (int i = 0; i < 15; i++) begin
            r.w[i] = s.w[i + 1];
        end
        r.w[15] = wn;
        sha_round = r;
    endfunction

endpackage

FILE: hdl/mdsha_core.sv
// Unrolled SHA-256 compression: input register, 64 registered round stages, feed-forward register.
// Depends on mdsha_pkg.
module mdsha_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  mdsha_pkg::state_t    in_base,
    input  mdsha_pkg::sched_t    in_block,
    output logic                 out_valid,
    output mdsha_pkg::state_t    out_hash
);

    localparam int unsigned N = mdsha_pkg::NumRounds;

    mdsha_pkg::slot_t  slot_reg  [N+1];
    logic [N:0]        vld_reg;
    mdsha_pkg::state_t hash_reg;
    logic              hvld_reg;

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            hvld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg  <= {vld_reg[N-1:0], in_valid};
            hvld_reg <= vld_reg[N];
        end
    end

    // Round stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            slot_reg[0].wv   <= in_base;
            slot_reg[0].w    <= in_block;
            slot_reg[0].base <= in_base;
            for (int i = 0; i < N; i++) begin
                slot_reg[i+1] <= mdsha_pkg::sha_round(slot_reg[i], mdsha_pkg::RoundK[i]);
            end
            // Feed-forward addition
            for (int j = 0; j < 8; j++) begin
                hash_reg[j] <= slot_reg[N].base[j] + slot_reg[N].wv[j];
            end
        end
    end

    assign out_valid = hvld_reg;
    assign out_hash  = hash_reg;

endmodule

FILE: hdl/midstate_double_sha256_target_check_unit.sv
// Top level: midstate SHA-256, second standard SHA-256, compact target compare.
// Depends on mdsha_pkg and mdsha_core.
//
//  Port group | Direction | Payload
//  s_         | in        | tail_word_0..5, nonce (416 bits)
//  m_         | out       | hash_word_0..3, meets_target (264 bits)
//  cfg_       | in        | midstate_pair_0..3, target_bits by index
//
// One item per cycle while the output is not stalled; 134 register stages (two 66-stage
// compressions, target compare stage, output register). The whole pipeline advances
// only while the output register is free or being taken, so a stall holds every stage.
// Reset clears valid bits and loads the default registers; takes effect next cycle.
module midstate_double_sha256_target_check_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tail_word_0 [63:0] .. tail_word_5 [383:320], nonce [415:384]
    input  logic [415:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hash_word_0 [63:0] .. hash_word_3 [255:192], meets_target [256], zero fill
    output logic [263:0] m_tdata,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_wdata
);

    mdsha_pkg::state_t mid_reg;
    logic [31:0]       tbits_reg;
    logic              adv;
    mdsha_pkg::sched_t blk1;
    mdsha_pkg::sched_t blk2;
    logic [31:0]       nonce;
    logic              v1;
    logic              v2;
    mdsha_pkg::state_t h1;
    mdsha_pkg::state_t h2;
    logic [255:0]      tgt_reg;
    logic [255:0]      dig_le;
    logic              ovld_reg;
    logic [255:0]      ohash_reg;
    logic              ometa_reg;
    logic              cvld_reg;
    logic [255:0]      chash_reg;
    logic [255:0]      cdig_reg;

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg   <= '0;
            tbits_reg <= mdsha_pkg::TargetReset;
        end else if (cfg_we) begin
            case (cfg_index)
                mdsha_pkg::RegMid0: {mid_reg[0], mid_reg[1]} <= cfg_wdata;
                mdsha_pkg::RegMid1: {mid_reg[2], mid_reg[3]} <= cfg_wdata;
                mdsha_pkg::RegMid2: {mid_reg[4], mid_reg[5]} <= cfg_wdata;
                mdsha_pkg::RegMid3: {mid_reg[6], mid_reg[7]} <= cfg_wdata;
                mdsha_pkg::RegTarget: tbits_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Decoded target, big number; recomputed only from config
    always_ff @(posedge aclk) begin
        logic [7:0]  ex;
        logic [23:0] man;
        ex  = tbits_reg[31:24];
        man = {1'b0, tbits_reg[22:0]};
        if (tbits_reg[23]) begin
            tgt_reg <= '0;
        end else if (ex <= 8'd3) begin
            tgt_reg <= {232'd0, man >> {(8'd3 - ex), 3'b000}};
        end else begin
            tgt_reg <= {232'd0, man} << {(ex - 8'd3), 3'b000};
        end
    end

    // Whole pipeline moves when output can take a new item
    assign adv      = !ovld_reg || m_tready;
    assign s_tready = adv;

    // First block
    assign nonce = s_tdata[415:384];
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            blk1[2*i]   = s_tdata[64*i+32 +: 32];
            blk1[2*i+1] = s_tdata[64*i +: 32];
        end
        blk1[3]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
        blk1[12] = mdsha_pkg::PadFirst;
        blk1[13] = '0;
        blk1[14] = '0;
        blk1[15] = mdsha_pkg::LenFirst;
    end

    mdsha_core u_first (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_tvalid), .in_base(mid_reg), .in_block(blk1),
        .out_valid(v1), .out_hash(h1)
    );

    // Second block: digest plus standard padding
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            blk2[i] = h1[i];
        end
        blk2[8] = mdsha_pkg::PadFirst;
        for (int i = 9; i < 15; i++) begin
            blk2[i] = '0;
        end
        blk2[15] = mdsha_pkg::LenSecond;
    end

    mdsha_core u_second (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(v1), .in_base(mdsha_pkg::StdIv), .in_block(blk2),
        .out_valid(v2), .out_hash(h2)
    );

    // Digest read little-endian: byte 31 most significant
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            for (int b = 0; b < 4; b++) begin
                dig_le[8*(4*i+b) +: 8] = h2[i][31-8*b -: 8];
            end
        end
    end

    // Compare stage then output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvld_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end else if (adv) begin
            cvld_reg <= v2;
            ovld_reg <= cvld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                chash_reg[64*i +: 64] <= {h2[2*i], h2[2*i+1]};
            end
            cdig_reg  <= dig_le;
            ohash_reg <= chash_reg;
            ometa_reg <= (cdig_reg <= tgt_reg);
        end
    end

    assign m_tvalid = ovld_reg;
    assign m_tdata  = {7'd0, ometa_reg, ohash_reg};

endmodule

FILE: dv/tb_midstate_double_sha256_target_check_unit.sv
// Testbench for midstate_double_sha256_target_check_unit: a behavioral double SHA-256
// and compact target decoder predict each result; stream traffic is checked in order.
// Depends on mdsha_pkg (types, round constants, IV, register indexes) and the unit RTL.
module tb_midstate_double_sha256_target_check_unit;

    typedef struct packed {
        logic [3:0][63:0] hash;
        logic             meets;
    } digest_rec_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [415:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [263:0] m_tdata;
    logic         cfg_we;
    logic [2:0]   cfg_index;
    logic [63:0]  cfg_wdata;

    midstate_double_sha256_target_check_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow registers
    logic [3:0][63:0] mid_shadow;
    logic [31:0]      bits_shadow;

    digest_rec_t pending_digests[$];
    int unsigned errors;
    int unsigned sent_count;
    int unsigned checked_count;
    int unsigned meets_count;
    int unsigned quiet_cycles;
    int unsigned idle_mode;  // 0 none, 1 sender, 2 receiver, 3 both

    // Clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic mdsha_pkg::word_t ror32(mdsha_pkg::word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression with feed-forward
    function automatic mdsha_pkg::state_t sha_compress(mdsha_pkg::state_t h,
                                                       mdsha_pkg::sched_t blk);
        mdsha_pkg::word_t w[64];
        mdsha_pkg::word_t a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
        mdsha_pkg::state_t r;
        for (int i = 0; i < 16; i++) w[i] = blk[i];
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = h[0]; b = h[1]; c = h[2]; d = h[3];
        e = h[4]; f = h[5]; g = h[6]; hh = h[7];
        for (int i = 0; i < 64; i++) begin
            t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                 + ((e & f) ^ (~e & g)) + mdsha_pkg::RoundK[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            hh = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c; r[3] = h[3] + d;
        r[4] = h[4] + e; r[5] = h[5] + f; r[6] = h[6] + g; r[7] = h[7] + hh;
        return r;
    endfunction

    // Compact bits to a 256-bit target; sign bit or exponent above 34 gives zero, higher bits drop
    function automatic logic [255:0] decode_compact(logic [31:0] cbits);
        logic [7:0]   expo;
        logic [287:0] wide;
        expo = cbits[31:24];
        wide = '0;
        if (!cbits[23]) begin
            if (expo <= 8'd3) wide = {264'd0, cbits[23:0] >> (8 * (3 - expo))};
            else if (expo - 3 < 32) wide = {264'd0, cbits[23:0]} << (8 * (expo - 3));
        end
        return wide[255:0];
    endfunction

    function automatic digest_rec_t predict_digest(logic [5:0][63:0] tail, logic [31:0] nonce);
        mdsha_pkg::sched_t blk;
        mdsha_pkg::state_t h;
        logic [255:0]      le_value;
        digest_rec_t       rec;
        for (int i = 0; i < 6; i++) begin
            blk[2*i]   = tail[i][63:32];
            blk[2*i+1] = tail[i][31:0];
        end
        blk[3]  = {nonce[7:0], nonce[15:8], nonce[23:16], nonce[31:24]};
        blk[12] = 32'h8000_0000;
        blk[13] = '0;
        blk[14] = '0;
        blk[15] = 32'h0000_0400;
        for (int i = 0; i < 4; i++) begin
            h[2*i]   = mid_shadow[i][63:32];
            h[2*i+1] = mid_shadow[i][31:0];
        end
        h = sha_compress(h, blk);
        for (int i = 0; i < 8; i++) blk[i] = h[i];
        blk[8] = 32'h8000_0000;
        for (int i = 9; i < 15; i++) blk[i] = '0;
        blk[15] = 32'd256;
        h = sha_compress(mdsha_pkg::StdIv, blk);
        // digest byte k lands at bits 8k+7:8k of the little-endian value
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 4; j++)
                le_value[8*(4*i+j) +: 8] = h[i][31-8*j -: 8];
        for (int i = 0; i < 4; i++) rec.hash[i] = {h[2*i], h[2*i+1]};
        rec.meets = (le_value <= decode_compact(bits_shadow));
        return rec;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want,
                 checked_count);
        errors++;
    endtask

    // Result checker
    always @(posedge aclk) begin
        digest_rec_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_digests.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[63:0], '0);
            end else begin
                want = pending_digests.pop_front();
                for (int i = 0; i < 4; i++)
                    if (m_tdata[64*i +: 64] !== want.hash[i])
                        report_mismatch($sformatf("hash_word_%0d", i),
                                        m_tdata[64*i +: 64], want.hash[i]);
                if (m_tdata[256] !== want.meets)
                    report_mismatch("meets_target", {63'd0, m_tdata[256]},
                                    {63'd0, want.meets});
                if (want.meets) meets_count++;
            end
            checked_count++;
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else if (idle_mode == 2) m_tready <= ($urandom_range(99) >= 68);
        else if (idle_mode == 3) m_tready <= ($urandom_range(99) >= 20);
        else m_tready <= 1'b1;
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 5000) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_item(logic [5:0][63:0] tail, logic [31:0] nonce);
        int unsigned pct;
        pct = (idle_mode == 1) ? 68 : (idle_mode == 3) ? 20 : 0;
        while ($urandom_range(99) < pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {nonce, tail};
        do @(posedge aclk); while (!s_tready);
        pending_digests.push_back(predict_digest(tail, nonce));
        sent_count++;
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_digests.size() != 0) @(posedge aclk);
        repeat (140) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx <= mdsha_pkg::RegMid3) mid_shadow[idx[1:0]] = value;
        else if (idx == mdsha_pkg::RegTarget) bits_shadow = value[31:0];
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [5:0][63:0] rand_tail();
        logic [5:0][63:0] t;
        for (int i = 0; i < 6; i++) begin
            case ($urandom_range(9))
                0: t[i] = '0;
                1: t[i] = '1;
                default: t[i] = rand64();
            endcase
        end
        return t;
    endfunction

    // Reset defaults, field extremes, ignored nonce slot bits
    task automatic test_directed();
        logic [5:0][63:0] t;
        idle_mode = 0;
        t = '0;
        send_item(t, 32'h0);
        send_item('1, 32'hffff_ffff);
        t = '0;
        t[1] = 64'h0000_0000_dead_beef;
        send_item(t, 32'h0);
        send_item(t, 32'h0000_0001);
        send_item(t, 32'h8000_0000);
        send_item(rand_tail(), 32'h1234_5678);
        wait_idle();
        write_reg(mdsha_pkg::RegMid0, 64'h6a09e667_bb67ae85);
        write_reg(mdsha_pkg::RegMid1, 64'h3c6ef372_a54ff53a);
        write_reg(mdsha_pkg::RegMid2, '1);
        write_reg(mdsha_pkg::RegMid3, 64'h0);
        for (int i = 0; i < 4; i++) send_item(rand_tail(), $urandom);
        wait_idle();
        // unused indexes must not disturb anything
        write_reg(3'd5, rand64());
        write_reg(3'd7, '1);
        for (int i = 0; i < 3; i++) send_item(rand_tail(), $urandom);
        wait_idle();
    endtask

    // Compact decode corners: sign bit, small and large exponents
    task automatic test_target_corners();
        logic [31:0] corners[10];
        corners = '{32'h1d80ffff, 32'h00ffffff, 32'h017fffff, 32'h027fffff,
                    32'h037fffff, 32'h227fffff, 32'h21ffffff, 32'h237fffff,
                    32'hff7fffff, 32'hffffffff};
        foreach (corners[k]) begin
            write_reg(mdsha_pkg::RegTarget, {32'h0, corners[k]});
            send_item(rand_tail(), $urandom);
            send_item(rand_tail(), $urandom);
            wait_idle();
        end
    endtask

    // Random traffic across idle modes and register settings
    task automatic test_random_traffic();
        logic [31:0] tb_bits;
        for (int ph = 0; ph < 16; ph++) begin
            idle_mode = ph % 4;
            for (int i = 0; i < 4; i++)
                if ($urandom_range(1)) write_reg(3'(i), rand64());
            case ($urandom_range(3))
                0: tb_bits = $urandom;
                1: tb_bits = {8'h22, 1'b0, 23'($urandom)};
                2: tb_bits = {8'(32 + $urandom_range(2)), 1'b0, 23'($urandom)};
                default: tb_bits = 32'h1d00ffff;
            endcase
            write_reg(mdsha_pkg::RegTarget, {32'h0, tb_bits});
            for (int i = 0; i < 120; i++) send_item(rand_tail(), $urandom);
            wait_idle();
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        idle_mode = 0;
        errors = 0;
        sent_count = 0;
        checked_count = 0;
        meets_count = 0;
        quiet_cycles = 0;
        mid_shadow  = '0;
        bits_shadow = mdsha_pkg::TargetReset;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_target_corners();
        test_random_traffic();

        $display("covered %0d transfers in, %0d results checked, %0d meeting target",
                 sent_count, checked_count, meets_count);
        $display("idle modes: none, sender gaps, receiver stalls, both");
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
